// File: hdl/wfc_pkg.sv
// shared constants, types and codes of the windowed fault classifier
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package wfc_pkg;

   // window depth and derived widths
   localparam int WINDOW   = 16;
   localparam int IDX_W    = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int LOG_W    = $clog2(WINDOW) + 1;
   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = 3 * SAMPLE_W;
   localparam int SUM_W    = 17 + LOG_W;   // signed sums of samples and steps
   localparam int SQ_W     = 33 + LOG_W;   // sums of squares
   localparam int XSUM_W   = 34 + LOG_W;   // signed sum of step cross products
   localparam int SP_W     = SQ_W + LOG_W; // spreads and |c|
   localparam int A_W      = 32 + SP_W;    // serial multiplier operand a
   localparam int B_W      = SP_W;         // serial multiplier operand b
   localparam int P_W      = A_W + B_W;    // serial multiplier product

   // fault classes
   localparam logic [2:0] FC_NONE  = 3'd0;
   localparam logic [2:0] FC_STUCK = 3'd1;
   localparam logic [2:0] FC_LOSS  = 3'd2;
   localparam logic [2:0] FC_BIAS  = 3'd3;
   localparam logic [2:0] FC_NOISE = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_RESIDUAL_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_MOTION_LIMIT      = 3'd1;
   localparam logic [2:0] CSR_CORRELATION_LIMIT = 3'd2;
   localparam logic [2:0] CSR_BIAS_RATIO        = 3'd3;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } ram_ctl_type;

   typedef struct packed {
      logic           start;
      logic [A_W-1:0] a;
      logic [B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [P_W-1:0] p;
   } mul_rsp_type;

endpackage

`default_nettype wire

// File: hdl/windowed_fault_classifier.sv
// top level of the windowed fault classifier: control sequencer and datapath
// depends on wfc_pkg, wfc_ring_ram and wfc_serial_mul
`timescale 1ns / 1ps
`default_nettype none

// Each req transfer carries one Q8.8 sample of residual, command and measurement;
// it is written into a ring memory of WINDOW entries and exactly one rsp transfer
// follows with a fault class (0 none, 1 actuator stuck, 2 actuator loss,
// 3 sensor bias, 4 sensor noise). Until WINDOW samples have been taken since
// reset the class is none, and it passes through the done state into the rsp
// register. With a full window the block walks the ring oldest first: for each
// entry one memory read, then five products through a shared 17x17 multiplier.
// It then runs thirteen products through a shift-add multiplier, each taking
// longer the more significant bits its second operand has, with the spread logic
// after the ninth; then the compare logic runs and the class goes to the rsp
// register, so the time from a transfer to rsp_valid depends on the data and the
// register values. req_stall is high from the transfer until the result has moved
// into the rsp register; that register holds a result while the next sample is
// taken. Registers are to be written through the csr port only while the block is
// idle; the block does not enforce this. csr_ready is always high. The ring
// needs no clearing after reset, as entries are only read once all are written.
module windowed_fault_classifier (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // sample channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [15:0]            req_residual,
   input  wire logic signed [15:0]            req_command,
   input  wire logic signed [15:0]            req_measurement,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_fault_class,
   // register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [15:0]                   csr_data
);

   localparam int IDX_W  = wfc_pkg::IDX_W;
   localparam int CNT_W  = wfc_pkg::CNT_W;
   localparam int SUM_W  = wfc_pkg::SUM_W;
   localparam int SQ_W   = wfc_pkg::SQ_W;
   localparam int XSUM_W = wfc_pkg::XSUM_W;
   localparam int SP_W   = wfc_pkg::SP_W;
   localparam int A_W    = wfc_pkg::A_W;
   localparam int B_W    = wfc_pkg::B_W;
   localparam int P_W    = wfc_pkg::P_W;
   localparam int WIN    = wfc_pkg::WINDOW;

   // phases of one entry in the sum pass
   localparam logic [2:0] PH_READ = 3'd0;
   localparam logic [2:0] PH_RR   = 3'd1;
   localparam logic [2:0] PH_UU   = 3'd2;
   localparam logic [2:0] PH_DUDU = 3'd3;
   localparam logic [2:0] PH_DYDY = 3'd4;
   localparam logic [2:0] PH_DUDY = 3'd5;

   // products taken by the shift-add multiplier, in order
   localparam logic [3:0] MS_RL   = 4'd0;
   localparam logic [3:0] MS_ML   = 4'd1;
   localparam logic [3:0] MS_CL   = 4'd2;
   localparam logic [3:0] MS_BR   = 4'd3;
   localparam logic [3:0] MS_SU   = 4'd4;
   localparam logic [3:0] MS_SR   = 4'd5;
   localparam logic [3:0] MS_SDU  = 4'd6;
   localparam logic [3:0] MS_SDY  = 4'd7;
   localparam logic [3:0] MS_DUY  = 4'd8;
   localparam logic [3:0] MS_C    = 4'd9;
   localparam logic [3:0] MS_CLSD = 4'd10;
   localparam logic [3:0] MS_RHS  = 4'd11;
   localparam logic [3:0] MS_BIAS = 4'd12;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_MSTART,
      S_MWAIT,
      S_SPREAD,
      S_CLASS,
      S_DONE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wp_ff, wp_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [2:0]         ph_ff, ph_in;
   logic [3:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_class_ff, rsp_class_in;

   // configuration
   logic [14:0]        rl_ff, rl_in;
   logic [14:0]        ml_ff, ml_in;
   logic [15:0]        cl_ff, cl_in;
   logic [15:0]        br_ff, br_in;

   // window sums
   logic signed [SUM_W-1:0]  sr_ff, sr_in, su_ff, su_in;
   logic signed [SUM_W-1:0]  sdu_ff, sdu_in, sdy_ff, sdy_in;
   logic [SQ_W-1:0]          srr_ff, srr_in, suu_ff, suu_in;
   logic [SQ_W-1:0]          sdudu_ff, sdudu_in, sdydy_ff, sdydy_in;
   logic signed [XSUM_W-1:0] sdudy_ff, sdudy_in;
   logic signed [16:0]       prev_u_ff, prev_u_in, prev_y_ff, prev_y_in;

   // products and spreads
   logic [31:0]              rlsq_ff, rlsq_in, mlsq_ff, mlsq_in;
   logic [31:0]              clsq_ff, clsq_in, brsq_ff, brsq_in;
   logic [2*SUM_W-1:0]       su2_ff, su2_in, sr2_ff, sr2_in;
   logic [2*SUM_W-1:0]       sdu2_ff, sdu2_in, sdy2_ff, sdy2_in, duy_ff, duy_in;
   logic [2*SP_W-1:0]        c2_ff, c2_in;
   logic [A_W-1:0]           t_ff, t_in, brhs_ff, brhs_in;
   logic [P_W-1:0]           rhs_ff, rhs_in;
   logic [SP_W-1:0]          spu_ff, spu_in, spr_ff, spr_in;
   logic [SP_W-1:0]          spd_ff, spd_in, spy_ff, spy_in;
   logic signed [SP_W:0]     c_ff, c_in;
   logic [2:0]               cls_ff, cls_in;

   // datapath nets
   logic                       acc_go;
   logic                       first_entry;
   logic [IDX_W:0]             rd_sum;
   logic [IDX_W-1:0]           rd_idx;
   logic [IDX_W-1:0]           wp_next;
   logic [CNT_W-1:0]           fill_next;
   logic [wfc_pkg::ENTRY_W-1:0] rdata;
   logic signed [15:0]         r_s, u_s, y_s;
   logic signed [16:0]         du, dy;
   logic signed [16:0]         ma, mb;
   logic signed [33:0]         mp;
   logic [SUM_W-1:0]           su_mag, sr_mag, sdu_mag, sdy_mag;
   logic [SP_W-1:0]            c_mag;
   logic [SP_W-1:0]            spr_raw;
   logic signed [SP_W:0]       c_lin, duy_s;
   logic [SP_W-1:0]            fl_rms, fl_stuck, fl_step;
   logic [P_W-1:0]             corr_lhs, bias_lhs;
   wfc_pkg::ram_ctl_type       ram_ctl;
   wfc_pkg::mul_req_type       mul_req;
   wfc_pkg::mul_rsp_type       mul_rsp;

   wfc_ring_ram u_ring (
      .clock (clock),
      .ctl   (ram_ctl),
      .rdata (rdata)
   );

   wfc_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // handshakes
   assign req_stall = (state_ff != S_IDLE);
   assign acc_go    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fault_class = rsp_class_ff;

   // ring addressing: the oldest entry sits at the write pointer
   assign wp_next   = (wp_ff == IDX_W'(WIN - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_next = (fill_ff == CNT_W'(WIN)) ? fill_ff : fill_ff + 1'b1;
   assign rd_sum    = {1'b0, wp_ff} + (IDX_W + 1)'(idx_ff);
   assign rd_idx    = (rd_sum >= (IDX_W + 1)'(WIN)) ?
                      IDX_W'(rd_sum - (IDX_W + 1)'(WIN)) : IDX_W'(rd_sum);

   always_comb begin
      ram_ctl.we    = acc_go;
      ram_ctl.waddr = wp_ff;
      ram_ctl.wdata = {req_residual, req_command, req_measurement};
      ram_ctl.re    = (state_ff == S_ACC) && (ph_ff == PH_READ);
      ram_ctl.raddr = rd_idx;
   end

   // current entry and its steps against the previous entry
   assign r_s = $signed(rdata[47:32]);
   assign u_s = $signed(rdata[31:16]);
   assign y_s = $signed(rdata[15:0]);
   assign du  = 17'(u_s) - prev_u_ff;
   assign dy  = 17'(y_s) - prev_y_ff;
   assign first_entry = (idx_ff == '0);

   // shared 17x17 multiplier of the sum pass
   always_comb begin
      case (ph_ff)
         PH_RR: begin
            ma = 17'(r_s);
            mb = 17'(r_s);
         end
         PH_UU: begin
            ma = 17'(u_s);
            mb = 17'(u_s);
         end
         PH_DUDU: begin
            ma = du;
            mb = du;
         end
         PH_DYDY: begin
            ma = dy;
            mb = dy;
         end
         default: begin
            ma = du;
            mb = dy;
         end
      endcase
   end
   assign mp = ma * mb;

   // magnitudes fed to the shift-add multiplier
   assign su_mag  = SUM_W'(su_ff[SUM_W-1] ? -su_ff : su_ff);
   assign sr_mag  = SUM_W'(sr_ff[SUM_W-1] ? -sr_ff : sr_ff);
   assign sdu_mag = SUM_W'(sdu_ff[SUM_W-1] ? -sdu_ff : sdu_ff);
   assign sdy_mag = SUM_W'(sdy_ff[SUM_W-1] ? -sdy_ff : sdy_ff);
   assign c_mag   = SP_W'(c_ff[SP_W] ? -c_ff : c_ff);

   always_comb begin
      mul_req.start = (state_ff == S_MSTART);
      case (step_ff)
         MS_RL: begin
            mul_req.a = A_W'(rl_ff);
            mul_req.b = B_W'(rl_ff);
         end
         MS_ML: begin
            mul_req.a = A_W'(ml_ff);
            mul_req.b = B_W'(ml_ff);
         end
         MS_CL: begin
            mul_req.a = A_W'(cl_ff);
            mul_req.b = B_W'(cl_ff);
         end
         MS_BR: begin
            mul_req.a = A_W'(br_ff);
            mul_req.b = B_W'(br_ff);
         end
         MS_SU: begin
            mul_req.a = A_W'(su_mag);
            mul_req.b = B_W'(su_mag);
         end
         MS_SR: begin
            mul_req.a = A_W'(sr_mag);
            mul_req.b = B_W'(sr_mag);
         end
         MS_SDU: begin
            mul_req.a = A_W'(sdu_mag);
            mul_req.b = B_W'(sdu_mag);
         end
         MS_SDY: begin
            mul_req.a = A_W'(sdy_mag);
            mul_req.b = B_W'(sdy_mag);
         end
         MS_DUY: begin
            mul_req.a = A_W'(sdu_mag);
            mul_req.b = B_W'(sdy_mag);
         end
         MS_C: begin
            mul_req.a = A_W'(c_mag);
            mul_req.b = B_W'(c_mag);
         end
         MS_CLSD: begin
            mul_req.a = A_W'(clsq_ff);
            mul_req.b = B_W'(spd_ff);
         end
         MS_RHS: begin
            mul_req.a = t_ff;
            mul_req.b = B_W'(spy_ff);
         end
         default: begin
            mul_req.a = A_W'(brsq_ff);
            mul_req.b = B_W'(spr_ff);
         end
      endcase
   end

   // spreads: n * sum x^2 - (sum x)^2, and the step covariance c
   assign spr_raw = SP_W'(WIN) * SP_W'(srr_ff) - SP_W'(sr2_ff);
   assign c_lin   = (SP_W + 1)'(sdudy_ff) * $signed((SP_W + 1)'(WIN - 1));
   assign duy_s   = $signed((SP_W + 1)'(duy_ff));

   // floors and left-hand sides of the final compares
   assign fl_rms   = SP_W'(WIN) * SP_W'(rlsq_ff);
   assign fl_stuck = SP_W'(WIN * WIN) * SP_W'(mlsq_ff);
   assign fl_step  = SP_W'((WIN - 1) * (WIN - 1)) * SP_W'(mlsq_ff);
   assign corr_lhs = P_W'({c2_ff, 32'd0});
   assign bias_lhs = P_W'({sr2_ff, 16'd0});

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      ph_in        = ph_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_class_in = rsp_class_ff;
      rl_in        = rl_ff;
      ml_in        = ml_ff;
      cl_in        = cl_ff;
      br_in        = br_ff;
      sr_in        = sr_ff;
      su_in        = su_ff;
      sdu_in       = sdu_ff;
      sdy_in       = sdy_ff;
      srr_in       = srr_ff;
      suu_in       = suu_ff;
      sdudu_in     = sdudu_ff;
      sdydy_in     = sdydy_ff;
      sdudy_in     = sdudy_ff;
      prev_u_in    = prev_u_ff;
      prev_y_in    = prev_y_ff;
      rlsq_in      = rlsq_ff;
      mlsq_in      = mlsq_ff;
      clsq_in      = clsq_ff;
      brsq_in      = brsq_ff;
      su2_in       = su2_ff;
      sr2_in       = sr2_ff;
      sdu2_in      = sdu2_ff;
      sdy2_in      = sdy2_ff;
      duy_in       = duy_ff;
      c2_in        = c2_ff;
      t_in         = t_ff;
      rhs_in       = rhs_ff;
      brhs_in      = brhs_ff;
      spu_in       = spu_ff;
      spr_in       = spr_ff;
      spd_in       = spd_ff;
      spy_in       = spy_ff;
      c_in         = c_ff;
      cls_in       = cls_ff;

      // register writes, masked to their widths
      if (csr_valid) begin
         case (csr_index)
            wfc_pkg::CSR_RESIDUAL_LIMIT:    rl_in = csr_data[14:0];
            wfc_pkg::CSR_MOTION_LIMIT:      ml_in = csr_data[14:0];
            wfc_pkg::CSR_CORRELATION_LIMIT: cl_in = csr_data;
            wfc_pkg::CSR_BIAS_RATIO:        br_in = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (acc_go) begin
               wp_in    = wp_next;
               fill_in  = fill_next;
               idx_in   = '0;
               ph_in    = PH_READ;
               sr_in    = '0;
               su_in    = '0;
               sdu_in   = '0;
               sdy_in   = '0;
               srr_in   = '0;
               suu_in   = '0;
               sdudu_in = '0;
               sdydy_in = '0;
               sdudy_in = '0;
               if (fill_next < CNT_W'(WIN)) begin
                  // window still filling
                  cls_in   = wfc_pkg::FC_NONE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               PH_RR: begin
                  sr_in  = sr_ff + SUM_W'(r_s);
                  su_in  = su_ff + SUM_W'(u_s);
                  srr_in = srr_ff + SQ_W'($unsigned(mp));
               end
               PH_UU: begin
                  suu_in = suu_ff + SQ_W'($unsigned(mp));
               end
               PH_DUDU: begin
                  if (!first_entry) begin
                     sdudu_in = sdudu_ff + SQ_W'($unsigned(mp));
                  end
               end
               PH_DYDY: begin
                  if (!first_entry) begin
                     sdydy_in = sdydy_ff + SQ_W'($unsigned(mp));
                  end
               end
               PH_DUDY: begin
                  if (!first_entry) begin
                     sdudy_in = sdudy_ff + XSUM_W'(mp);
                     sdu_in   = sdu_ff + SUM_W'(du);
                     sdy_in   = sdy_ff + SUM_W'(dy);
                  end
                  prev_u_in = 17'(u_s);
                  prev_y_in = 17'(y_s);
                  ph_in     = PH_READ;
                  idx_in    = idx_ff + 1'b1;
                  if (idx_ff == CNT_W'(WIN - 1)) begin
                     step_in  = MS_RL;
                     state_in = S_MSTART;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MSTART: begin
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (mul_rsp.done) begin
               case (step_ff)
                  MS_RL:   rlsq_in = mul_rsp.p[31:0];
                  MS_ML:   mlsq_in = mul_rsp.p[31:0];
                  MS_CL:   clsq_in = mul_rsp.p[31:0];
                  MS_BR:   brsq_in = mul_rsp.p[31:0];
                  MS_SU:   su2_in  = mul_rsp.p[2*SUM_W-1:0];
                  MS_SR:   sr2_in  = mul_rsp.p[2*SUM_W-1:0];
                  MS_SDU:  sdu2_in = mul_rsp.p[2*SUM_W-1:0];
                  MS_SDY:  sdy2_in = mul_rsp.p[2*SUM_W-1:0];
                  MS_DUY:  duy_in  = mul_rsp.p[2*SUM_W-1:0];
                  MS_C:    c2_in   = mul_rsp.p[2*SP_W-1:0];
                  MS_CLSD: t_in    = mul_rsp.p[A_W-1:0];
                  MS_RHS:  rhs_in  = mul_rsp.p;
                  default: brhs_in = mul_rsp.p[A_W-1:0];
               endcase
               step_in = step_ff + 1'b1;
               if (step_ff == MS_DUY) begin
                  state_in = S_SPREAD;
               end else if (step_ff == MS_BIAS) begin
                  state_in = S_CLASS;
               end else begin
                  state_in = S_MSTART;
               end
            end
         end
         S_SPREAD: begin
            spu_in = SP_W'(WIN) * SP_W'(suu_ff) - SP_W'(su2_ff);
            // a flat residual window counts as one lsb of spread
            spr_in = (spr_raw == '0) ? SP_W'(WIN * WIN) : spr_raw;
            spd_in = SP_W'(WIN - 1) * SP_W'(sdudu_ff) - SP_W'(sdu2_ff);
            spy_in = SP_W'(WIN - 1) * SP_W'(sdydy_ff) - SP_W'(sdy2_ff);
            c_in   = (sdu_ff[SUM_W-1] ^ sdy_ff[SUM_W-1]) ? c_lin + duy_s : c_lin - duy_s;
            state_in = S_MSTART;
         end
         S_CLASS: begin
            if (SP_W'(srr_ff) < fl_rms) begin
               cls_in = wfc_pkg::FC_NONE;
            end else if (spu_ff < fl_stuck) begin
               cls_in = wfc_pkg::FC_STUCK;
            end else if ((spd_ff > fl_step) &&
                         ((spy_ff <= fl_step) || (corr_lhs < rhs_ff))) begin
               cls_in = wfc_pkg::FC_LOSS;
            end else if (bias_lhs > P_W'(brhs_ff)) begin
               cls_in = wfc_pkg::FC_BIAS;
            end else begin
               cls_in = wfc_pkg::FC_NOISE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // move the class into the rsp register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = cls_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         ph_ff        <= PH_READ;
         step_ff      <= MS_RL;
         rsp_valid_ff <= 1'b0;
         rsp_class_ff <= wfc_pkg::FC_NONE;
         rl_ff        <= 15'd256;
         ml_ff        <= 15'd8;
         cl_ff        <= 16'd19661;
         br_ff        <= 16'd512;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         ph_ff        <= ph_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_class_ff <= rsp_class_in;
         rl_ff        <= rl_in;
         ml_ff        <= ml_in;
         cl_ff        <= cl_in;
         br_ff        <= br_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sr_ff     <= sr_in;
      su_ff     <= su_in;
      sdu_ff    <= sdu_in;
      sdy_ff    <= sdy_in;
      srr_ff    <= srr_in;
      suu_ff    <= suu_in;
      sdudu_ff  <= sdudu_in;
      sdydy_ff  <= sdydy_in;
      sdudy_ff  <= sdudy_in;
      prev_u_ff <= prev_u_in;
      prev_y_ff <= prev_y_in;
      rlsq_ff   <= rlsq_in;
      mlsq_ff   <= mlsq_in;
      clsq_ff   <= clsq_in;
      brsq_ff   <= brsq_in;
      su2_ff    <= su2_in;
      sr2_ff    <= sr2_in;
      sdu2_ff   <= sdu2_in;
      sdy2_ff   <= sdy2_in;
      duy_ff    <= duy_in;
      c2_ff     <= c2_in;
      t_ff      <= t_in;
      rhs_ff    <= rhs_in;
      brhs_ff   <= brhs_in;
      spu_ff    <= spu_in;
      spr_ff    <= spr_in;
      spd_ff    <= spd_in;
      spy_ff    <= spy_in;
      c_ff      <= c_in;
      cls_ff    <= cls_in;
   end

   // a class outside the five codes never leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault_class <= wfc_pkg::FC_NOISE))
      else $error("fault class out of range");

   // while the window is still filling every waiting result is none
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (fill_ff < CNT_W'(WIN))) |-> (rsp_fault_class == wfc_pkg::FC_NONE))
      else $error("fault reported before the window was full");

   // the shift-add multiplier is finished whenever a new sample can be taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mul_rsp.busy)
      else $error("multiplier still running while idle");

endmodule

`default_nettype wire

// File: hdl/wfc_ring_ram.sv
// sample ring memory: one write port, one registered read port
// depends on wfc_pkg for depth, entry width and the control struct
`timescale 1ns / 1ps
`default_nettype none

module wfc_ring_ram (
   input  wire logic                         clock,
   input  wire wfc_pkg::ram_ctl_type         ctl,
   output logic [wfc_pkg::ENTRY_W-1:0]       rdata
);

   logic [wfc_pkg::ENTRY_W-1:0] mem [wfc_pkg::WINDOW];
   logic [wfc_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata_ff <= mem[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/wfc_serial_mul.sv
// shift-add multiplier, one bit of b per cycle, stops when b runs out
// depends on wfc_pkg for operand widths and request/response structs
`timescale 1ns / 1ps
`default_nettype none

module wfc_serial_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wfc_pkg::mul_req_type req,
   output wfc_pkg::mul_rsp_type      rsp
);

   logic                      run_ff, run_in;
   logic [wfc_pkg::P_W-1:0]   acc_ff, acc_in;
   logic [wfc_pkg::P_W-1:0]   a_ff, a_in;
   logic [wfc_pkg::B_W-1:0]   b_ff, b_in;

   always_comb begin
      run_in = run_ff;
      acc_in = acc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      if (req.start) begin
         run_in = 1'b1;
         acc_in = '0;
         a_in   = wfc_pkg::P_W'(req.a);
         b_in   = req.b;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.busy = run_ff;
   assign rsp.done = run_ff && (b_ff == '0);
   assign rsp.p    = acc_ff;

endmodule

`default_nettype wire

// File: tb/tb_windowed_fault_classifier.sv
// self-checking testbench of the windowed fault classifier
// holds its own bit-exact class predictor; depends on wfc_pkg and windowed_fault_classifier
`timescale 1ns / 1ps

module tb_windowed_fault_classifier;

   typedef logic [255:0] wide_type;

   localparam int WINDOW = wfc_pkg::WINDOW;

   // stimulus flavors of one window worth of samples
   localparam int SC_WILD   = 0;
   localparam int SC_QUIET  = 1;
   localparam int SC_STUCK  = 2;
   localparam int SC_FLAT   = 3;
   localparam int SC_UNCORR = 4;
   localparam int SC_BIAS   = 5;
   localparam int SC_NOISE  = 6;

   localparam int STALL_LIMIT  = 5000;  // cycles with no transfer at all
   localparam int RANDOM_ITEMS = 1700;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_residual;
   logic signed [15:0] req_command;
   logic signed [15:0] req_measurement;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_fault_class;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   // predictor state
   logic signed [15:0] res_ring [WINDOW];
   logic signed [15:0] cmd_ring [WINDOW];
   logic signed [15:0] meas_ring [WINDOW];
   int                 wr_ptr;
   int                 filled;
   logic [14:0]        lim_residual;
   logic [14:0]        lim_motion;
   logic [15:0]        lim_corr;
   logic [15:0]        lim_bias;

   logic [2:0] pending_classes[$];
   int         errors;
   int         items_sent;
   bit         idle_on;
   int         hold_len;
   int         quiet_cycles;

   windowed_fault_classifier i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_residual    (req_residual),
      .req_command     (req_command),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fault_class (rsp_fault_class),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // class predictor: exact integer form of the rms, spread, correlation and bias tests
   // ---------------------------------------------------------------------
   function automatic logic [2:0] classify_window();
      longint   sr, su, sdu, sdy, sdudy, srr, suu, sdudu, sdydy;
      longint   r, u, y, pu, py, du, dy, spu, spd, spy, spr, c, m;
      wide_type lhs, rhs, flr;
      int       k;
      sr = 0; su = 0; sdu = 0; sdy = 0; sdudy = 0;
      srr = 0; suu = 0; sdudu = 0; sdydy = 0; pu = 0; py = 0;
      // walk oldest first so steps are newer minus older
      for (int i = 0; i < WINDOW; i++) begin
         k = (wr_ptr + i) % WINDOW;
         r = res_ring[k];
         u = cmd_ring[k];
         y = meas_ring[k];
         sr += r; srr += r * r;
         su += u; suu += u * u;
         if (i > 0) begin
            du = u - pu;
            dy = y - py;
            sdu += du; sdy += dy;
            sdudu += du * du; sdydy += dy * dy;
            sdudy += du * dy;
         end
         pu = u;
         py = y;
      end
      // rms floor
      if (wide_type'(srr) < wide_type'(WINDOW) * lim_residual * lim_residual)
         return wfc_pkg::FC_NONE;
      // command spread
      spu = WINDOW * suu - su * su;
      if (wide_type'(spu) < wide_type'(WINDOW * WINDOW) * lim_motion * lim_motion)
         return wfc_pkg::FC_STUCK;
      // step motion and correlation
      spd = (WINDOW - 1) * sdudu - sdu * sdu;
      spy = (WINDOW - 1) * sdydy - sdy * sdy;
      flr = wide_type'((WINDOW - 1) * (WINDOW - 1)) * lim_motion * lim_motion;
      if (wide_type'(spd) > flr) begin
         if (wide_type'(spy) <= flr) return wfc_pkg::FC_LOSS;
         c = (WINDOW - 1) * sdudy - sdu * sdy;
         if (c < 0) c = -c;
         lhs = (wide_type'(c) * c) << 32;
         rhs = wide_type'(lim_corr) * lim_corr * spd * spy;
         if (lhs < rhs) return wfc_pkg::FC_LOSS;
      end
      // residual mean against spread; flat residual counts as one lsb
      spr = WINDOW * srr - sr * sr;
      if (spr == 0) spr = WINDOW * WINDOW;
      m = (sr < 0) ? -sr : sr;
      m = m * 256;
      if (wide_type'(m) * m > wide_type'(lim_bias) * lim_bias * spr) return wfc_pkg::FC_BIAS;
      return wfc_pkg::FC_NOISE;
   endfunction

   function automatic logic [2:0] store_and_classify(logic signed [15:0] r,
                                                     logic signed [15:0] u,
                                                     logic signed [15:0] y);
      res_ring[wr_ptr]  = r;
      cmd_ring[wr_ptr]  = u;
      meas_ring[wr_ptr] = y;
      wr_ptr = (wr_ptr + 1) % WINDOW;
      if (filled < WINDOW) filled++;
      if (filled < WINDOW) return wfc_pkg::FC_NONE;
      return classify_window();
   endfunction

   function automatic int spread_rand(int amp);
      return int'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   // ---------------------------------------------------------------------
   // shared drivers
   // ---------------------------------------------------------------------
   task automatic send_sample(logic signed [15:0] r, logic signed [15:0] u,
                              logic signed [15:0] y);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_residual    <= r;
      req_command     <= u;
      req_measurement <= y;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge
      pending_classes.push_back(store_and_classify(r, u, y));
      items_sent++;
   endtask

   // bring the block to idle before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_classes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         wfc_pkg::CSR_RESIDUAL_LIMIT:    lim_residual = value[14:0];
         wfc_pkg::CSR_MOTION_LIMIT:      lim_motion   = value[14:0];
         wfc_pkg::CSR_CORRELATION_LIMIT: lim_corr     = value;
         wfc_pkg::CSR_BIAS_RATIO:        lim_bias     = value;
         default: ;  // out of range index, ignored
      endcase
      @(posedge clock);
   endtask

   task automatic write_limits(int mode);
      drain();
      case (mode)
         0: begin  // reset values
            csr_write(wfc_pkg::CSR_RESIDUAL_LIMIT, 16'd256);
            csr_write(wfc_pkg::CSR_MOTION_LIMIT, 16'd8);
            csr_write(wfc_pkg::CSR_CORRELATION_LIMIT, 16'd19661);
            csr_write(wfc_pkg::CSR_BIAS_RATIO, 16'd512);
         end
         1: begin  // all zero
            csr_write(wfc_pkg::CSR_RESIDUAL_LIMIT, 16'd0);
            csr_write(wfc_pkg::CSR_MOTION_LIMIT, 16'd0);
            csr_write(wfc_pkg::CSR_CORRELATION_LIMIT, 16'd0);
            csr_write(wfc_pkg::CSR_BIAS_RATIO, 16'd0);
         end
         2: begin  // all ones, upper bit of 15 bit registers masked
            csr_write(wfc_pkg::CSR_RESIDUAL_LIMIT, 16'hffff);
            csr_write(wfc_pkg::CSR_MOTION_LIMIT, 16'hffff);
            csr_write(wfc_pkg::CSR_CORRELATION_LIMIT, 16'hffff);
            csr_write(wfc_pkg::CSR_BIAS_RATIO, 16'hffff);
         end
         3: begin  // near the reset values, correlation limit over its full range
            csr_write(wfc_pkg::CSR_RESIDUAL_LIMIT, 16'($urandom_range(0, 1200)));
            csr_write(wfc_pkg::CSR_MOTION_LIMIT, 16'($urandom_range(0, 64)));
            csr_write(wfc_pkg::CSR_CORRELATION_LIMIT, 16'($urandom_range(0, 65535)));
            csr_write(wfc_pkg::CSR_BIAS_RATIO, 16'($urandom_range(0, 2048)));
         end
         default: begin
            csr_write(wfc_pkg::CSR_RESIDUAL_LIMIT, 16'($urandom));
            csr_write(wfc_pkg::CSR_MOTION_LIMIT, 16'($urandom));
            csr_write(wfc_pkg::CSR_CORRELATION_LIMIT, 16'($urandom));
            csr_write(wfc_pkg::CSR_BIAS_RATIO, 16'($urandom));
         end
      endcase
      if ($urandom_range(0, 2) == 0) csr_write(3'($urandom_range(4, 7)), 16'($urandom));
   endtask

   // one run of samples shaped toward a given class
   task automatic send_window(int kind, int count);
      int rbase, ramp, ubase, uamp, ybase;
      int r, u, y;
      rbase = spread_rand(8000);
      ramp  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
      ubase = spread_rand(12000);
      uamp  = $urandom_range(500, 8000);
      ybase = spread_rand(12000);
      for (int i = 0; i < count; i++) begin
         case (kind)
            SC_QUIET: r = spread_rand(150);
            SC_BIAS:  r = rbase + spread_rand(ramp);
            SC_WILD:  r = int'($urandom);
            default:  r = spread_rand(uamp + 400);
         endcase
         case (kind)
            SC_STUCK: u = ubase + spread_rand(2);
            SC_WILD:  u = int'($urandom);
            default:  u = ubase + spread_rand(uamp);
         endcase
         case (kind)
            SC_FLAT:   y = ybase + spread_rand(1);
            SC_UNCORR: y = spread_rand(8000);
            SC_WILD:   y = int'($urandom);
            default:   y = u + spread_rand(30);
         endcase
         send_sample(16'(r), 16'(u), 16'(y));
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // first window: class none while filling, extremes of every field
   task automatic test_fill_window();
      logic signed [15:0] pick [4];
      pick[0] = 16'sh7fff;
      pick[1] = 16'sh8000;
      pick[2] = 16'sh0000;
      pick[3] = 16'shffff;
      for (int i = 0; i < WINDOW + 4; i++)
         send_sample(pick[i % 4], pick[(i + 1) % 4], pick[(i + 3) % 4]);
   endtask

   // register writes: masking, ignored indexes, every setting mode
   task automatic test_register_access();
      for (int mode = 0; mode < 5; mode++) begin
         write_limits(mode);
         send_window(SC_WILD, 2);
         send_window(SC_NOISE, 2);
      end
      write_limits(0);
   endtask

   // receiver holds off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      drain();
      hold_len = 1000;
      send_window(SC_NOISE, 10);
   endtask

   task automatic test_random_windows();
      int phase, kind;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 6) == 0) kind = SC_WILD;
         else kind = $urandom_range(SC_QUIET, SC_NOISE);
         send_window(kind, $urandom_range(16, 40));
         phase++;
         if (phase % 10 == 0) begin
            // mostly settings that let every class show up
            if ($urandom_range(0, 3) == 0) write_limits($urandom_range(1, 4));
            else write_limits(($urandom_range(0, 1) == 0) ? 0 : 3);
         end
      end
   endtask

   // last stretch with no idling on either side
   task automatic test_no_idle_tail();
      write_limits(0);
      idle_on = 1'b0;
      for (int i = 0; i < 6; i++) send_window($urandom_range(SC_QUIET, SC_NOISE), 20);
   endtask

   // ---------------------------------------------------------------------
   // receiver: random stall bursts and the long hold
   // ---------------------------------------------------------------------
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result check against the oldest expected class
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_classes.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual class %0d",
                     $time, rsp_fault_class);
            errors++;
         end else begin
            if (rsp_fault_class !== pending_classes[0]) begin
               $display("%0t: fault_class mismatch, expected %0d, actual %0d",
                        $time, pending_classes[0], rsp_fault_class);
               errors++;
            end
            void'(pending_classes.pop_front());
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_windowed_fault_classifier: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_residual    = '0;
      req_command     = '0;
      req_measurement = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      errors          = 0;
      items_sent      = 0;
      idle_on         = 1'b1;
      hold_len        = 0;
      quiet_cycles    = 0;
      for (int i = 0; i < WINDOW; i++) begin
         res_ring[i]  = '0;
         cmd_ring[i]  = '0;
         meas_ring[i] = '0;
      end
      wr_ptr       = 0;
      filled       = 0;
      lim_residual = 15'd256;
      lim_motion   = 15'd8;
      lim_corr     = 16'd19661;
      lim_bias     = 16'd512;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_window();
      test_register_access();
      test_backpressure();
      test_random_windows();
      test_no_idle_tail();

      drain();
      repeat (600) @(posedge clock);
      if (errors == 0 && pending_classes.size() == 0)
         $display("tb_windowed_fault_classifier: PASS");
      else
         $display("tb_windowed_fault_classifier: FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/wfc_pkg.sv
hdl/wfc_ring_ram.sv
hdl/wfc_serial_mul.sv
hdl/windowed_fault_classifier.sv
tb/tb_windowed_fault_classifier.sv
